// ----- design/spq_pkg.sv -----
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int FILL_W   = 5;

    localparam logic signed [31:0] EMPTY_MARK = -32'sd100001;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_SPARE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] priority_req;
        logic signed [31:0] value;
    } spq_req_t;

    typedef struct packed {
        logic signed [31:0] head_priority;
        logic signed [31:0] head_value;
        logic               is_empty;
        logic [FILL_W-1:0]  fill_count;
        logic [1:0]         status;
    } spq_rsp_t;

    typedef struct packed {
        logic signed [31:0] prio;
        logic signed [31:0] value;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_IDLE   = 2'd3
    } cell_op_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctl_t;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell (
    input  logic              clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic              occ,
    input  logic              left_keep,
    input  spq_pkg::entry_t   left_entry,
    input  spq_pkg::entry_t   right_entry,
    output logic              keep,
    output spq_pkg::entry_t   entry,
    output spq_pkg::entry_t   entry_next
);
    import spq_pkg::*;

    entry_t entry_reg;

    // stays put when it sorts at or ahead of the new priority
    assign keep  = occ && (entry_reg.prio <= ctl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            OP_INSERT:
            begin
                if (keep)
                begin
                    entry_next = entry_reg;
                end
                else if (left_keep)
                begin
                    entry_next = ctl.new_entry;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
            OP_SHIFT:
            begin
                entry_next = right_entry;
            end
            OP_HOLD, OP_IDLE:
            begin
                entry_next = entry_reg;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/sorted_priority_queue_core.sv -----
// channel   direction  ports              transfer when
// command   in         start, busy, req   start high and busy low at a rising edge
// result    out        done, rsp          done high for one cycle, taken at its end
//
// one command is taken per cycle; busy is always low
// every cell compares its entry with the new priority in parallel, so an insert,
// a head removal or a peek completes in the cycle it is taken
// the result appears on rsp with done in the cycle after the command transfer
// reset empties the queue at once; the receiver cannot stall, results are never held
module sorted_priority_queue_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::spq_req_t req,
    output logic              done,
    output spq_pkg::spq_rsp_t rsp
);
    import spq_pkg::*;

    // occupancy of the row; entries at or above the count are stale
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               done_reg;
    spq_rsp_t           rsp_reg;
    spq_rsp_t           rsp_next;

    cell_ctl_t          ctl;
    status_t            status;

    logic   [CAPACITY-1:0] occ;
    logic   [CAPACITY-1:0] keep;
    entry_t                cell_entry [CAPACITY];
    entry_t                cell_entry_next [CAPACITY];

    logic is_full;
    logic is_none;

    assign busy    = 1'b0;
    assign is_full = (count_reg == COUNT_W'(CAPACITY));
    assign is_none = (count_reg == '0);

    // decode the command into a single row operation
    always_comb
    begin
        ctl.op        = OP_HOLD;
        ctl.new_entry = '{prio: req.priority_req, value: req.value};
        status        = ST_OK;
        count_next    = count_reg;
        if (start)
        begin
            unique case (req.cmd)
                CMD_ENQUEUE:
                begin
                    if (is_full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        ctl.op     = OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (is_none)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.op     = OP_SHIFT;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    // peek and the spare code change nothing
                    ctl.op = OP_HOLD;
                end
            endcase
        end
    end

    // the row of cells, head at index zero
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        assign occ[g] = (COUNT_W'(g) < count_reg);

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occ         (occ[g]),
            .left_keep   ((g == 0) ? 1'b1 : keep[(g == 0) ? 0 : g - 1]),
            .left_entry  (cell_entry[(g == 0) ? 0 : g - 1]),
            .right_entry (cell_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .keep        (keep[g]),
            .entry       (cell_entry[g]),
            .entry_next  (cell_entry_next[g])
        );
    end

    // result describes the head after the operation
    always_comb
    begin
        rsp_next.is_empty   = (count_next == '0);
        rsp_next.fill_count = FILL_W'(count_next);
        rsp_next.status     = status;
        if (count_next == '0)
        begin
            rsp_next.head_priority = EMPTY_MARK;
            rsp_next.head_value    = EMPTY_MARK;
        end
        else
        begin
            rsp_next.head_priority = cell_entry_next[0].prio;
            rsp_next.head_value    = cell_entry_next[0].value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // every accepted command yields exactly one result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("missing result strobe");

    // the reported fill matches the live count
    a_fill_match: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.fill_count == FILL_W'(count_reg)))
        else $error("fill count out of step");

    // an enqueue to a full queue is dropped with the full status
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        start && (req.cmd == CMD_ENQUEUE) && is_full |=> (rsp.status == ST_FULL)
            && $stable(count_reg))
        else $error("full enqueue not dropped");

    // empty flag and marker agree
    a_empty_mark: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.is_empty |-> (rsp.head_priority == EMPTY_MARK)
            && (rsp.head_value == EMPTY_MARK))
        else $error("empty marker missing");

endmodule
